FILE: sv/qlru_pkg.sv
package qlru_pkg;

  // access modes
  localparam logic [1:0] MODE_HIT  = 2'd0;
  localparam logic [1:0] MODE_MISS = 2'd1;
  localparam logic [1:0] MODE_INV  = 2'd2;

  // victim rules
  localparam logic [1:0] VIC_FRONT_FLAG = 2'd0;
  localparam logic [1:0] VIC_FRONT_WAY0 = 2'd1;
  localparam logic [1:0] VIC_BACK_FLAG  = 2'd2;

  // hit age maps
  localparam logic [2:0] HIT_H00 = 3'd0;
  localparam logic [2:0] HIT_H10 = 3'd1;
  localparam logic [2:0] HIT_H11 = 3'd2;
  localparam logic [2:0] HIT_H20 = 3'd3;
  localparam logic [2:0] HIT_H21 = 3'd4;

  // age update rules
  localparam logic [1:0] UPD_RAISE_ALL    = 2'd0;
  localparam logic [1:0] UPD_RAISE_OTHERS = 2'd1;
  localparam logic [1:0] UPD_INC_ALL      = 2'd2;
  localparam logic [1:0] UPD_INC_OTHERS   = 2'd3;

  localparam logic [1:0] AGE_MAX = 2'd3;

  // register indexes (byte address = 4 * index)
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_VICTIM_RULE  = 3'd0;
  localparam logic [2:0] REG_HIT_RULE     = 3'd1;
  localparam logic [2:0] REG_INSERT_AGE   = 3'd2;
  localparam logic [2:0] REG_UPDATE_RULE  = 3'd3;
  localparam logic [2:0] REG_UPD_MISS_ONLY = 3'd4;

  // age of a way after a hit, per hit map
  function automatic logic [1:0] hit_age(input logic [1:0] age, input logic [2:0] rule);
    logic [1:0] res;
    res = 2'd0;
    if (age == 2'd2) begin
      if (rule == HIT_H11 || rule == HIT_H21) begin
        res = 2'd1;
      end
    end else if (age == AGE_MAX) begin
      if (rule == HIT_H10 || rule == HIT_H11) begin
        res = 2'd1;
      end else if (rule == HIT_H20 || rule == HIT_H21) begin
        res = 2'd2;
      end
    end
    return res;
  endfunction

endpackage

FILE: sv/qlru_replacement_policy.sv
// Quad-age LRU replacement state for a set-associative cache.
//
// Input channel (in_valid / in_stall): one access per transfer, carrying
// in_mode (hit, miss, invalidate), in_set_index and in_hit_way.
// Result channel (out_valid / out_stall): one result per access, carrying
// out_victim_way and out_no_candidate (both zero except on a miss).
// Config (cfg_ APB port, 4-byte spaced registers): victim_rule, hit_rule,
// insert_age, update_rule, update_on_miss_only; write only while idle.
//
// Throughput: one access per cycle while in_stall is low. The set state lives
// in a single-port write / single-port read memory; an access reads its set at
// the transfer edge, then the compute stage computes the new ages/valids,
// writes them back and loads the result register when it advances.
// A read of the set being written back in the same cycle is forwarded.
//
// Reset: a clearing pass writes every set with all ages zero and all ways
// invalid; in_stall stays high until it is done.
// Receiver stall: the result register holds; one more access can sit in
// the compute stage, after which in_stall goes high.
module qlru_replacement_policy #(
  parameter int unsigned WAYS = 16,
  parameter int unsigned SETS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // access channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [9:0]  in_set_index,
  input  logic [3:0]  in_hit_way,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_victim_way,
  output logic        out_no_candidate,
  // config port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [qlru_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned WI     = $clog2(WAYS);
  localparam int unsigned SA     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WORD_W = 3 * WAYS;

  typedef logic [WAYS-1:0][1:0] age_vec_t;
  typedef logic [WAYS-1:0]      vld_vec_t;

  // one age-normalizing pass; skip_en excludes way skip where the rule says so
  function automatic age_vec_t run_upd(input age_vec_t a, input logic [1:0] rule,
                                       input logic skip_en, input logic [WI-1:0] skip);
    age_vec_t   res;
    vld_vec_t   incl;
    vld_vec_t   hi_v;
    vld_vec_t   lo_v;
    vld_vec_t   m3_v;
    vld_vec_t   all3_v;
    logic [1:0] top;
    logic       others;
    logic       any3;
    logic [1:0] inc;
    others = (rule == qlru_pkg::UPD_RAISE_OTHERS) || (rule == qlru_pkg::UPD_INC_OTHERS);
    for (int i = 0; i < WAYS; i++) begin
      incl[i]   = !(others && skip_en && (skip == WI'(i)));
      hi_v[i]   = incl[i] & a[i][1];
      lo_v[i]   = incl[i] & a[i][0];
      m3_v[i]   = incl[i] & a[i][1] & a[i][0];
      all3_v[i] = a[i][1] & a[i][0];
    end
    any3 = |all3_v;
    if (|m3_v) begin
      top = qlru_pkg::AGE_MAX;
    end else if (|hi_v) begin
      top = 2'd2;
    end else begin
      top = {1'b0, |lo_v};
    end
    res = a;
    case (rule)
      qlru_pkg::UPD_RAISE_ALL, qlru_pkg::UPD_RAISE_OTHERS: begin
        inc = qlru_pkg::AGE_MAX - top;
        for (int i = 0; i < WAYS; i++) begin
          if (incl[i]) begin
            res[i] = a[i] + inc;
          end
        end
      end
      default: begin
        if (!any3) begin
          for (int i = 0; i < WAYS; i++) begin
            if (incl[i]) begin
              res[i] = a[i] + 2'd1;
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  // ---------------- config registers ----------------
  logic [1:0] victim_rule_r;
  logic [2:0] hit_rule_r;
  logic [1:0] insert_age_r;
  logic [1:0] update_rule_r;
  logic       upd_miss_only_r;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      victim_rule_r   <= qlru_pkg::VIC_FRONT_FLAG;
      hit_rule_r      <= qlru_pkg::HIT_H00;
      insert_age_r    <= 2'd1;
      update_rule_r   <= qlru_pkg::UPD_RAISE_ALL;
      upd_miss_only_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        qlru_pkg::REG_VICTIM_RULE:   victim_rule_r   <= cfg_pwdata[1:0];
        qlru_pkg::REG_HIT_RULE:      hit_rule_r      <= cfg_pwdata[2:0];
        qlru_pkg::REG_INSERT_AGE:    insert_age_r    <= cfg_pwdata[1:0];
        qlru_pkg::REG_UPDATE_RULE:   update_rule_r   <= cfg_pwdata[1:0];
        qlru_pkg::REG_UPD_MISS_ONLY: upd_miss_only_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      qlru_pkg::REG_VICTIM_RULE:   cfg_prdata = {30'd0, victim_rule_r};
      qlru_pkg::REG_HIT_RULE:      cfg_prdata = {29'd0, hit_rule_r};
      qlru_pkg::REG_INSERT_AGE:    cfg_prdata = {30'd0, insert_age_r};
      qlru_pkg::REG_UPDATE_RULE:   cfg_prdata = {30'd0, update_rule_r};
      qlru_pkg::REG_UPD_MISS_ONLY: cfg_prdata = {31'd0, upd_miss_only_r};
      default:                     cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- handshake / stage control ----------------
  logic          clr_busy_r;
  logic [SA-1:0] clr_cnt_r;
  logic          s1_valid_r;
  logic          s1_adv;
  logic          in_xfer;
  logic          out_valid_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clr_busy_r || (s1_valid_r && !s1_adv);
  assign in_xfer  = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // set address for the incoming access
  logic [16:0]   in_set_ext;
  logic [SA-1:0] in_addr;
  assign in_set_ext = 17'(in_set_index);
  assign in_addr    = in_set_ext[SA-1:0];

  // ---------------- compute stage registers ----------------
  logic [1:0]        s1_mode_r;
  logic [3:0]        s1_way_r;
  logic              s1_set_ok_r;
  logic [SA-1:0]     s1_addr_r;
  logic [WORD_W-1:0] rd_data_r;

  logic              wr_en;
  logic [SA-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              s1_wr;
  logic [WORD_W-1:0] s1_wr_data;

  logic [WORD_W-1:0] mem [SETS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode_r   <= in_mode;
      s1_way_r    <= in_hit_way;
      s1_set_ok_r <= in_set_ext < 17'(SETS);
      s1_addr_r   <= in_addr;
      // forward a write-back to the same set in this cycle
      if (wr_en && (wr_addr == in_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[in_addr];
      end
    end
  end

  // ---------------- clearing pass ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == SA'(SETS - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  assign wr_en   = clr_busy_r || (s1_adv && s1_wr);
  assign wr_addr = clr_busy_r ? clr_cnt_r : s1_addr_r;
  assign wr_data = clr_busy_r ? '0 : s1_wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // ---------------- set update logic ----------------
  age_vec_t      cur_age;
  vld_vec_t      cur_vld;
  age_vec_t      hit_a1;
  age_vec_t      hit_a2;
  age_vec_t      miss_a0;
  age_vec_t      miss_a1;
  age_vec_t      miss_a2;
  vld_vec_t      miss_vld;
  vld_vec_t      inv_vld;
  logic [4:0]    way5;
  logic [WI-1:0] widx;
  logic          way_ok;
  logic [WI-1:0] free_front;
  logic [WI-1:0] free_back;
  logic [WI-1:0] old_idx;
  logic          any_free;
  logic          any_old;
  logic          back_scan;
  logic [WI-1:0] vic;
  logic          vic_flag;
  logic [3:0]    res_way;
  logic          res_flag;

  assign cur_age = rd_data_r[2*WAYS-1:0];
  assign cur_vld = rd_data_r[WORD_W-1:2*WAYS];
  assign way5    = 5'(s1_way_r);
  assign widx    = way5[WI-1:0];
  assign way_ok  = 6'(s1_way_r) < 6'(WAYS);

  // hit path
  always_comb begin
    hit_a1       = cur_age;
    hit_a1[widx] = qlru_pkg::hit_age(cur_age[widx], hit_rule_r);
    hit_a2       = upd_miss_only_r ? hit_a1 : run_upd(hit_a1, update_rule_r, 1'b1, widx);
  end

  // miss path: optional pre-update, victim choice, fill, post-update
  assign miss_a0   = upd_miss_only_r ? run_upd(cur_age, update_rule_r, 1'b0, '0) : cur_age;
  assign back_scan = (victim_rule_r != qlru_pkg::VIC_FRONT_FLAG) &&
                     (victim_rule_r != qlru_pkg::VIC_FRONT_WAY0);

  always_comb begin
    free_front = '0;
    free_back  = '0;
    old_idx    = '0;
    any_free   = 1'b0;
    any_old    = 1'b0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!cur_vld[i]) begin
        free_front = WI'(i);
      end
      if (miss_a0[i] == qlru_pkg::AGE_MAX) begin
        old_idx = WI'(i);
        any_old = 1'b1;
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      if (!cur_vld[i]) begin
        free_back = WI'(i);
        any_free  = 1'b1;
      end
    end
  end

  always_comb begin
    vic_flag = 1'b0;
    if (any_free) begin
      vic = back_scan ? free_back : free_front;
    end else if (any_old) begin
      vic = old_idx;
    end else begin
      vic      = '0;
      vic_flag = (victim_rule_r != qlru_pkg::VIC_FRONT_WAY0);
    end
  end

  always_comb begin
    miss_a1      = miss_a0;
    miss_a1[vic] = insert_age_r;
    miss_vld     = cur_vld;
    miss_vld[vic] = 1'b1;
    miss_a2      = upd_miss_only_r ? miss_a1 : run_upd(miss_a1, update_rule_r, 1'b1, vic);
    inv_vld       = cur_vld;
    inv_vld[widx] = 1'b0;
  end

  // select write-back and result
  always_comb begin
    s1_wr      = 1'b0;
    s1_wr_data = rd_data_r;
    res_way    = 4'd0;
    res_flag   = 1'b0;
    if (s1_set_ok_r) begin
      case (s1_mode_r)
        qlru_pkg::MODE_HIT: begin
          if (way_ok) begin
            s1_wr      = 1'b1;
            s1_wr_data = {cur_vld, hit_a2};
          end
        end
        qlru_pkg::MODE_MISS: begin
          s1_wr      = 1'b1;
          s1_wr_data = {miss_vld, miss_a2};
          res_way    = 4'(vic);
          res_flag   = vic_flag;
        end
        qlru_pkg::MODE_INV: begin
          if (way_ok) begin
            s1_wr      = 1'b1;
            s1_wr_data = {inv_vld, cur_age};
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- result register ----------------
  logic [3:0] out_way_r;
  logic       out_flag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_way_r  <= res_way;
      out_flag_r <= res_flag;
    end
  end

  assign out_victim_way   = out_way_r;
  assign out_no_candidate = out_flag_r;

endmodule
